// ----- hw/rtl/ipidr_pkg.sv -----
// Shared types and constants of the incremental PID controller with relay mode.
package ipidr_pkg;

   localparam int GAIN_WIDTH     = 16;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_GAIN_I     = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_OUT_MIN    = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_OUT_MAX    = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RELAY_MODE = 3'd5;

   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0] gain_p;
      logic [GAIN_WIDTH-1:0] gain_i;
      logic [GAIN_WIDTH-1:0] gain_d;
   } gains_type;

endpackage

// ----- hw/rtl/incremental_pid_with_relay.sv -----
// Incremental PID controller with relay mode: top level, registers and request flow.
// Each request (compute step or clear) gives exactly one drive response. It sits in
// an input register, and one stage computes the three gain products, the increment
// and the clamp and updates the error history (kept in relay mode), the held drive
// and the response register together, so consecutive steps see each other's state
// with no bubble. A new request can be taken every cycle unless the response
// register holds a result under stall and the input register is full.
// Configuration is always ready and takes effect on the next step.
module incremental_pid_with_relay import ipidr_pkg::*; #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic signed [DATA_WIDTH-1:0] req_setpoint,
   input  logic signed [DATA_WIDTH-1:0] req_measured,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_drive,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_ADDR_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam logic signed [DATA_WIDTH-1:0] MIN_RESET = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] MAX_RESET = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   gains_type                    gains_ff;
   logic signed [DATA_WIDTH-1:0] out_min_ff;
   logic signed [DATA_WIDTH-1:0] out_max_ff;
   logic                         relay_mode_ff;

   logic                         s1_valid_ff;
   logic                         s1_cmd_ff;
   logic signed [DATA_WIDTH-1:0] s1_setpoint_ff;
   logic signed [DATA_WIDTH-1:0] s1_measured_ff;

   logic signed [DATA_WIDTH:0]   err_newest_ff;
   logic signed [DATA_WIDTH:0]   err_previous_ff;
   logic signed [DATA_WIDTH:0]   err_oldest_ff;
   logic signed [DATA_WIDTH-1:0] drive_held_ff;
   logic signed [DATA_WIDTH-1:0] drive_held_in;
   logic signed [DATA_WIDTH:0]   err_newest_in;
   logic signed [DATA_WIDTH:0]   err_previous_in;
   logic signed [DATA_WIDTH:0]   err_oldest_in;

   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_drive_ff;

   logic                         s2_open;
   logic                         s2_load;
   logic                         s1_load;
   logic signed [DATA_WIDTH:0]   err_sample;
   logic signed [DATA_WIDTH-1:0] drive_step;

   assign csr_ready = 1'b1;
   assign s2_open   = !rsp_valid_ff || !rsp_stall;
   assign s2_load   = s1_valid_ff && s2_open;
   assign req_stall = s1_valid_ff && !s2_open;
   assign s1_load   = !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff      <= '0;
         out_min_ff    <= MIN_RESET;
         out_max_ff    <= MAX_RESET;
         relay_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GAIN_P:     gains_ff.gain_p <= csr_wdata[GAIN_WIDTH-1:0];
            REG_GAIN_I:     gains_ff.gain_i <= csr_wdata[GAIN_WIDTH-1:0];
            REG_GAIN_D:     gains_ff.gain_d <= csr_wdata[GAIN_WIDTH-1:0];
            REG_OUT_MIN:    out_min_ff      <= csr_wdata[DATA_WIDTH-1:0];
            REG_OUT_MAX:    out_max_ff      <= csr_wdata[DATA_WIDTH-1:0];
            REG_RELAY_MODE: relay_mode_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_cmd_ff      <= req_cmd;
         s1_setpoint_ff <= req_setpoint;
         s1_measured_ff <= req_measured;
      end
   end

   assign err_sample = (DATA_WIDTH+1)'(s1_setpoint_ff) - (DATA_WIDTH+1)'(s1_measured_ff);

   ipidr_step #(
      .DATA_WIDTH     (DATA_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_step (
      .gains          (gains_ff),
      .error_newest   (err_sample),
      .error_previous (err_newest_ff),
      .error_oldest   (err_previous_ff),
      .drive_held     (drive_held_ff),
      .out_min        (out_min_ff),
      .out_max        (out_max_ff),
      .drive_next     (drive_step)
   );

   always_comb begin
      err_newest_in   = err_newest_ff;
      err_previous_in = err_previous_ff;
      err_oldest_in   = err_oldest_ff;
      priority if (s1_cmd_ff == CMD_CLEAR) begin
         err_newest_in   = '0;
         err_previous_in = '0;
         err_oldest_in   = '0;
         drive_held_in   = '0;
      end else if (relay_mode_ff) begin
         drive_held_in = (s1_setpoint_ff > s1_measured_ff) ? out_max_ff : out_min_ff;
      end else begin
         err_newest_in   = err_sample;
         err_previous_in = err_newest_ff;
         err_oldest_in   = err_previous_ff;
         drive_held_in   = drive_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_newest_ff   <= '0;
         err_previous_ff <= '0;
         err_oldest_ff   <= '0;
         drive_held_ff   <= '0;
      end else if (s2_load) begin
         err_newest_ff   <= err_newest_in;
         err_previous_ff <= err_previous_in;
         err_oldest_ff   <= err_oldest_in;
         drive_held_ff   <= drive_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_drive_ff <= drive_held_in;
      end
   end

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_drive_ff == drive_held_ff))
      else $error("response drive differs from held drive");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_cmd_ff == CMD_CLEAR) |=>
         (drive_held_ff == '0 && err_newest_ff == '0 && err_oldest_ff == '0))
      else $error("clear left state nonzero");

   a_relay_keeps_history: assert property (@(posedge clock) disable iff (reset)
      (s2_load && s1_cmd_ff == CMD_STEP && relay_mode_ff) |=>
         ($stable(err_newest_ff) && $stable(err_previous_ff) && $stable(err_oldest_ff)))
      else $error("relay step changed error history");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with free stage");

endmodule

// ----- hw/rtl/ipidr_step.sv -----
// Velocity-form PID increment, wide accumulation and output clamp.
module ipidr_step import ipidr_pkg::*; #(
   parameter int DATA_WIDTH     = 16,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  gains_type                     gains,
   input  logic signed [DATA_WIDTH:0]    error_newest,
   input  logic signed [DATA_WIDTH:0]    error_previous,
   input  logic signed [DATA_WIDTH:0]    error_oldest,
   input  logic signed [DATA_WIDTH-1:0]  drive_held,
   input  logic signed [DATA_WIDTH-1:0]  out_min,
   input  logic signed [DATA_WIDTH-1:0]  out_max,
   output logic signed [DATA_WIDTH-1:0]  drive_next
);

   localparam int KW = GAIN_WIDTH + 2;
   localparam int PW = DATA_WIDTH + 1 + KW + 1;
   localparam int AW = PW + 2;
   localparam int SW = AW + 1;

   logic        [KW-1:0] k0;
   logic        [KW-1:0] k1;
   logic signed [KW:0]   k0_s;
   logic signed [KW:0]   k1_s;
   logic signed [KW:0]   k2_s;
   logic signed [PW-1:0] p0;
   logic signed [PW-1:0] p1;
   logic signed [PW-1:0] p2;
   logic signed [AW-1:0] acc;
   logic signed [AW-1:0] inc;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] lim_lo;
   logic signed [SW-1:0] lim_hi;

   always_comb begin
      k0   = {2'b00, gains.gain_p} + {2'b00, gains.gain_i} + {2'b00, gains.gain_d};
      k1   = {2'b00, gains.gain_p} + {1'b0, gains.gain_d, 1'b0};
      k0_s = $signed({1'b0, k0});
      k1_s = $signed({1'b0, k1});
      k2_s = $signed({3'b000, gains.gain_d});
      p0   = PW'(k0_s) * PW'(error_newest);
      p1   = PW'(k1_s) * PW'(error_previous);
      p2   = PW'(k2_s) * PW'(error_oldest);
      acc  = AW'(p0) - AW'(p1) + AW'(p2);
      inc  = acc >>> GAIN_FRAC_BITS;
      sum  = SW'(drive_held) + SW'(inc);
      lim_lo = SW'(out_min);
      lim_hi = SW'(out_max);
      priority if (sum > lim_hi) begin
         drive_next = out_max;
      end else if (sum < lim_lo) begin
         drive_next = out_min;
      end else begin
         drive_next = sum[DATA_WIDTH-1:0];
      end
   end

endmodule
